// ===== design/cfl_pkg.sv =====
// ----------------------------------------------------------------------------
// cfl_pkg
// Shared widths and codes for the cascaded fixed-point low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cfl_pkg;

    localparam int MAX_POLES   = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int DATA_W      = 32;
    localparam int POLE_IDX_W  = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;

    localparam int LAG_W       = 31;
    localparam int FRAC_W      = 5;
    localparam int POLE_CNT_W  = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = LAG_W;

    localparam logic [FRAC_W-1:0] FRAC_MIN   = FRAC_W'(1);
    localparam logic [FRAC_W-1:0] FRAC_MAX   = FRAC_W'(30);
    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(15);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAG_COEFF  = 2'd0,
        REG_FRAC_BITS  = 2'd1,
        REG_POLE_COUNT = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/cfl_ram.sv =====
// ----------------------------------------------------------------------------
// cfl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/cfl_mult.sv =====
// ----------------------------------------------------------------------------
// cfl_mult
// Split integer/fraction fixed-point multiply on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl_mult
    import cfl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] x,
    input  wire logic [LAG_W-1:0]  y,
    input  wire logic [FRAC_W-1:0] z,
    output logic                   done,
    output logic      [DATA_W-1:0] result
);

    typedef enum logic [1:0] {
        T_II = 2'd0,
        T_FI = 2'd1,
        T_IF = 2'd2,
        T_FF = 2'd3
    } term_t;

    logic [2:0]        step_reg;
    logic [DATA_W-1:0] xi_reg, xf_reg, yi_reg, yf_reg;
    logic [FRAC_W-1:0] z_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic              done_reg;

    logic [DATA_W-1:0] y_ext;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] op_a, op_b;
    logic [DATA_W-1:0] term;
    logic [DATA_W-1:0] fp_round;
    logic [DATA_W-1:0] acc_next;
    term_t             mul_kind;
    term_t             acc_kind;

    assign y_ext    = DATA_W'(y);
    assign mask     = (DATA_W'(1) << z) - DATA_W'(1);
    assign mul_kind = term_t'(2'(step_reg - 3'd1));
    assign acc_kind = term_t'(2'(step_reg - 3'd2));

    always_comb
    begin
        case (mul_kind)
            T_II:    begin op_a = xi_reg; op_b = yi_reg; end
            T_FI:    begin op_a = xf_reg; op_b = yi_reg; end
            T_IF:    begin op_a = xi_reg; op_b = yf_reg; end
            default: begin op_a = xf_reg; op_b = yf_reg; end
        endcase
    end

    // fraction product is rounded at half an LSB, then shifted arithmetically
    assign fp_round = prod_reg + (DATA_W'(1) << (z_reg - FRAC_W'(1)));

    always_comb
    begin
        case (acc_kind)
            T_II:    term = prod_reg << z_reg;
            T_FI:    term = prod_reg;
            T_IF:    term = prod_reg;
            default: term = DATA_W'($signed(fp_round) >>> z_reg);
        endcase
        acc_next = ((step_reg == 3'd2) ? '0 : acc_reg) + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == 3'd5);
            if (start)
            begin
                step_reg <= 3'd1;
            end
            else if (step_reg == 3'd5)
            begin
                step_reg <= '0;
            end
            else if (step_reg != 3'd0)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xi_reg <= DATA_W'($signed(x) >>> z);
            xf_reg <= x & mask;
            yi_reg <= y_ext >> z;
            yf_reg <= y_ext & mask;
            z_reg  <= z;
        end
        if (step_reg >= 3'd1 && step_reg <= 3'd4)
        begin
            prod_reg <= op_a * op_b;
        end
        if (step_reg >= 3'd2)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

// ===== design/cascaded_fixed_point_lowpass.sv =====
// ----------------------------------------------------------------------------
// cascaded_fixed_point_lowpass
// Cascaded single-pole fixed-point low-pass filter with pole state in RAM.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. Each stage in use takes a RAM read of
// the pole, the difference and its overflow check, and the steps of the
// shared multiplier, whose result is added and written back on the last.
// A restart (first sample after reset or after an overflow) loads the poles
// one per cycle. ok is low when an overflow threw the filter back to a
// restart; filtered then carries the scaled sample. The next sample is taken
// while a result is still waiting on the output.
`default_nettype none

module cascaded_fixed_point_lowpass
    import cfl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [DATA_W-1:0]      m_tdata,   // [31:0] filtered
    output logic                        m_tuser,   // [0] ok
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_DIFF,
        S_MULT,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [LAG_W-1:0]      lag_reg;
    logic [FRAC_W-1:0]     frac_reg;
    logic [POLE_CNT_W-1:0] poles_reg;
    logic                  restart_reg;
    logic [POLE_IDX_W-1:0] idx_reg;
    logic [DATA_W-1:0]     scaled_reg;
    logic [DATA_W-1:0]     cur_reg;
    logic [DATA_W-1:0]     pole_reg;
    logic [DATA_W-1:0]     res_reg;
    logic                  res_ok_reg;
    logic                  out_valid_reg;
    logic [DATA_W-1:0]     out_data_reg;
    logic                  out_ok_reg;

    logic [FRAC_W-1:0]     z_eff;
    logic [POLE_CNT_W-1:0] n_eff;
    logic                  last_pole;
    logic [DATA_W-1:0]     scaled_w;
    logic [DATA_W-1:0]     rd_data;
    logic [DATA_W-1:0]     diff;
    logic                  sub_ovf;
    logic [DATA_W-1:0]     prod;
    logic                  mult_done;
    logic [DATA_W-1:0]     sum;
    logic                  add_ovf;
    logic                  out_free;
    logic                  ram_we;
    logic [DATA_W-1:0]     ram_wdata;
    logic                  mult_start;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg   <= '0;
            frac_reg  <= FRAC_RESET;
            poles_reg <= POLE_CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LAG_COEFF:  lag_reg   <= cfg_data;
                REG_FRAC_BITS:  frac_reg  <= cfg_data[FRAC_W-1:0];
                REG_POLE_COUNT: poles_reg <= cfg_data[POLE_CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign z_eff = (frac_reg < FRAC_MIN) ? FRAC_MIN :
                   (frac_reg > FRAC_MAX) ? FRAC_MAX : frac_reg;
    assign n_eff = (32'(poles_reg) > MAX_POLES) ? POLE_CNT_W'(MAX_POLES) : poles_reg;
    assign last_pole = (32'(idx_reg) + 32'd1 == 32'(n_eff));

    assign scaled_w = DATA_W'($signed(s_tdata)) << z_eff;

    assign diff    = cur_reg - rd_data;
    assign sub_ovf = ((cur_reg[DATA_W-1] ^ rd_data[DATA_W-1]) &&
                      (cur_reg[DATA_W-1] ^ diff[DATA_W-1]));
    assign sum     = prod + pole_reg;
    assign add_ovf = (!(prod[DATA_W-1] ^ pole_reg[DATA_W-1]) &&
                      (prod[DATA_W-1] ^ sum[DATA_W-1]));

    assign out_free   = !out_valid_reg || m_tready;
    assign mult_start = (state_reg == S_DIFF) && !sub_ovf;
    assign ram_we     = (state_reg == S_FILL) ||
                        ((state_reg == S_MULT) && mult_done && !add_ovf);
    assign ram_wdata  = (state_reg == S_FILL) ? scaled_reg : sum;

    // each pole is read once and written back before the next one is read,
    // so read and write never meet on the same entry
    cfl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POLES)
    ) u_pole_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (state_reg == S_READ),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    cfl_mult u_mult (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mult_start),
        .x      (diff),
        .y      (lag_reg),
        .z      (z_eff),
        .done   (mult_done),
        .result (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            restart_reg   <= 1'b1;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_DONE the output register is refilled instead
            if (out_valid_reg && m_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        scaled_reg <= scaled_w;
                        cur_reg    <= scaled_w;
                        res_reg    <= scaled_w;
                        res_ok_reg <= 1'b1;
                        idx_reg    <= '0;
                        if (n_eff == '0)
                        begin
                            // nothing to load, but the restart is used up
                            restart_reg <= 1'b0;
                            state_reg   <= S_DONE;
                        end
                        else if (restart_reg)
                        begin
                            state_reg <= S_FILL;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FILL:
                begin
                    if (last_pole)
                    begin
                        restart_reg <= 1'b0;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + POLE_IDX_W'(1);
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    pole_reg <= rd_data;
                    if (sub_ovf)
                    begin
                        res_ok_reg  <= 1'b0;
                        restart_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_MULT;
                    end
                end
                S_MULT:
                begin
                    if (mult_done)
                    begin
                        if (add_ovf)
                        begin
                            res_ok_reg  <= 1'b0;
                            restart_reg <= 1'b1;
                            state_reg   <= S_DONE;
                        end
                        else if (last_pole)
                        begin
                            res_reg   <= sum;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cur_reg   <= sum;
                            idx_reg   <= idx_reg + POLE_IDX_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        out_ok_reg    <= res_ok_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

endmodule

`default_nettype wire

// ===== design/cfl_checker.sv =====
// ----------------------------------------------------------------------------
// cfl_checker
// Port-level checks for the cascaded fixed-point low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl_checker
    import cfl_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [DATA_W-1:0]      m_tdata,
    input wire logic                   m_tuser,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready
);

    logic [1:0] pend_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // items taken in but not yet handed out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input taken while previous sample still in work");

    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result offered with no sample outstanding");

    a_two_deep: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !s_tready)
        else $error("third sample accepted while two outstanding");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration beat refused");

endmodule

bind cascaded_fixed_point_lowpass cfl_checker u_cfl_checker (.*);

`default_nettype wire

// ===== sim/tb_cascaded_fixed_point_lowpass.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_fixed_point_lowpass
// Self-checking bench for the cascaded single-pole fixed-point low-pass.
// Samples are streamed in from a queue, each accepted beat is run through a
// bench-side filter model and the result beat is compared with the oldest
// prediction. Settings are changed between phases while the filter is idle.
// ----------------------------------------------------------------------------

module tb_cascaded_fixed_point_lowpass;

    import cfl_pkg::*;

    localparam int PERIOD_HALF   = 2;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_CYCLES  = 400;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int RANDOM_PHASES = 12;

    typedef struct packed {
        logic [DATA_W-1:0] filtered;
        logic              ok;
    } lp_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [DATA_W-1:0]      m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = REG_LAG_COEFF;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // filter model state
    logic [LAG_W-1:0]       lag_reg         = '0;
    logic [FRAC_W-1:0]      frac_reg        = FRAC_RESET;
    logic [POLE_CNT_W-1:0]  pole_count_reg  = POLE_CNT_W'(1);
    logic [DATA_W-1:0]      pole_state [MAX_POLES];
    bit                     restart_pending = 1'b1;
    int unsigned            poles_loaded    = 0;

    logic [SAMPLE_BITS-1:0] pending_samples [$];
    lp_result_t             expected_results [$];

    bit                     calm          = 1'b0;
    int unsigned            rx_hold_reqs  = 0;
    int unsigned            rx_hold_seen  = 0;
    int unsigned            rx_hold_left  = 0;
    int unsigned            fail_count    = 0;
    int unsigned            quiet_cycles  = 0;

    cascaded_fixed_point_lowpass i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #PERIOD_HALF clk = ~clk;
    end

    // split integer/fraction multiply, everything wraps at 32 bits
    function automatic logic [DATA_W-1:0] fixed_mul(logic [DATA_W-1:0] a,
                                                     logic [DATA_W-1:0] b,
                                                     int unsigned z);
        logic [DATA_W-1:0] mask, ai, bi, af, bf, fp;
        mask = (32'd1 << z) - 32'd1;
        ai   = $signed(a) >>> z;
        bi   = $signed(b) >>> z;
        af   = a & mask;
        bf   = b & mask;
        fp   = af * bf + (32'd1 << (z - 1));
        fp   = $signed(fp) >>> z;
        return ((ai * bi) << z) + af * bi + ai * bf + fp;
    endfunction

    function automatic lp_result_t filter_sample(logic [SAMPLE_BITS-1:0] sample);
        int unsigned       z, n;
        logic [DATA_W-1:0] scaled, cur, p, diff, prod, sum;
        lp_result_t        r;
        z = (frac_reg < FRAC_MIN) ? FRAC_MIN : (frac_reg > FRAC_MAX) ? FRAC_MAX : frac_reg;
        n = (pole_count_reg > MAX_POLES) ? MAX_POLES : pole_count_reg;
        scaled = {{(DATA_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample} << z;
        r.filtered = scaled;
        r.ok       = 1'b1;
        if (restart_pending)
        begin
            for (int i = 0; i < n; i++)
                pole_state[i] = scaled;
            if (n > poles_loaded)
                poles_loaded = n;
            restart_pending = 1'b0;
            return r;
        end
        cur = scaled;
        for (int i = 0; i < n; i++)
        begin
            p    = pole_state[i];
            diff = cur - p;
            if ((cur[DATA_W-1] ^ p[DATA_W-1]) && (cur[DATA_W-1] ^ diff[DATA_W-1]))
            begin
                r.ok = 1'b0;
                restart_pending = 1'b1;
                return r;
            end
            prod = fixed_mul(diff, {1'b0, lag_reg}, z);
            sum  = prod + p;
            if (!(prod[DATA_W-1] ^ p[DATA_W-1]) && (prod[DATA_W-1] ^ sum[DATA_W-1]))
            begin
                r.ok = 1'b0;
                restart_pending = 1'b1;
                return r;
            end
            pole_state[i] = sum;
            cur = sum;
        end
        r.filtered = cur;
        return r;
    endfunction

    // sample source: mostly a wandering signal, some jumps and full-scale hits
    function automatic logic [SAMPLE_BITS-1:0] next_sample(logic [SAMPLE_BITS-1:0] prev);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return prev + SAMPLE_BITS'($urandom_range(512)) - SAMPLE_BITS'(256);
        else if (pick < 90)
            return SAMPLE_BITS'($urandom);
        else if (pick[0])
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_LAG_COEFF:  lag_reg        = val[LAG_W-1:0];
            REG_FRAC_BITS:  frac_reg       = val[FRAC_W-1:0];
            REG_POLE_COUNT: pole_count_reg = val[POLE_CNT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // never let a stage be used that no restart has loaded yet
    task automatic configure(logic [CFG_DATA_W-1:0] lag, logic [CFG_DATA_W-1:0] frac,
                             logic [CFG_DATA_W-1:0] count);
        int unsigned stages;
        stages = (count[POLE_CNT_W-1:0] > MAX_POLES) ? MAX_POLES : count[POLE_CNT_W-1:0];
        if (stages > poles_loaded && !restart_pending)
            count = CFG_DATA_W'(poles_loaded);
        write_reg(REG_LAG_COEFF, lag);
        write_reg(REG_FRAC_BITS, frac);
        write_reg(REG_POLE_COUNT, count);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        logic                   nv;
        logic [SAMPLE_BITS-1:0] nd;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            nv = s_tvalid;
            nd = s_tdata;
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(filter_sample(s_tdata));
                nv = 1'b0;
            end
            if (!nv && pending_samples.size() != 0 && (calm || $urandom_range(99) >= 6))
            begin
                nv = 1'b1;
                nd = pending_samples.pop_front();
            end
            s_tvalid <= nv;
            s_tdata  <= nd;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        lp_result_t want;
        logic       nr;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: filtered %h ok %b",
                           m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.filtered)
                    begin
                        $error("filtered: expected %h, actual %h", want.filtered, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.ok)
                    begin
                        $error("ok: expected %b, actual %b", want.ok, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (rx_hold_seen != rx_hold_reqs)
            begin
                rx_hold_seen = rx_hold_reqs;
                rx_hold_left = STALL_CYCLES;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                nr = 1'b0;
            end
            else
                nr = calm || $urandom_range(99) >= 6;
            m_tready <= nr;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("cascaded_fixed_point_lowpass verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [SAMPLE_BITS-1:0] last_sample;
        logic [CFG_DATA_W-1:0]  lag, frac, count;
        int unsigned            n_items;
        bit                     noisy;

        last_sample = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings; the first beat restarts the single stage
        pending_samples.push_back(16'h7FFF); pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h0000); pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'h0001);
        wait_drained();

        // 16 fraction bits scale full-scale samples to the 32-bit limits: subtraction overflow both ways
        write_reg(REG_FRAC_BITS, CFG_DATA_W'(16));
        pending_samples.push_back(16'h7FFF); pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h8000); pending_samples.push_back(16'h7FFF);
        wait_drained();

        // restart pending: all stages (count clamped), fraction clamped high, max lag
        configure({CFG_DATA_W{1'b1}}, CFG_DATA_W'(31), CFG_DATA_W'(7));
        pending_samples.push_back(16'h0001); pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'h8000); pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h5555); pending_samples.push_back(16'hAAAA);
        wait_drained();

        // no stages: output is the scaled sample
        configure(CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(0));
        pending_samples.push_back(16'h8000); pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h1234);
        wait_drained();

        // fraction clamped low, three stages, plus a write to the spare index
        configure(CFG_DATA_W'(1), CFG_DATA_W'(0), CFG_DATA_W'(3));
        write_reg(REG_UNUSED, 31'h5A5A5A5A);
        pending_samples.push_back(16'h7FFF); pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h0000); pending_samples.push_back(16'hC001);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            noisy = (ph % 5 == 3);
            if (noisy)
            begin
                lag   = CFG_DATA_W'($urandom);
                frac  = CFG_DATA_W'($urandom);
                count = CFG_DATA_W'($urandom);
            end
            else
            begin
                // sensible filter: lag between 0 and 1.0 at the given scaling
                frac  = (ph == 1) ? CFG_DATA_W'(15) : CFG_DATA_W'($urandom_range(1, 15));
                lag   = (ph == 1) ? (CFG_DATA_W'(1) << frac)
                                  : CFG_DATA_W'($urandom_range(0, 1 << frac));
                count = CFG_DATA_W'($urandom_range(1, MAX_POLES));
            end
            configure(lag, frac, count);
            calm    = (ph == 2);
            n_items = $urandom_range(150, 170);
            for (int i = 0; i < n_items; i++)
            begin
                if (i == n_items / 2)
                begin
                    if (ph == 4)
                        rx_hold_reqs++;
                    if (ph == 6)
                        wait_drained();
                end
                last_sample = next_sample(last_sample);
                pending_samples.push_back(last_sample);
            end
            wait_drained();
            calm = 1'b0;
        end

        if (fail_count == 0)
            $display("cascaded_fixed_point_lowpass verification clean");
        else
            $display("cascaded_fixed_point_lowpass verification failed");
        $finish;
    end

endmodule
